@@ rtl/slfd_pkg.sv @@
// Shared types and constants for the length-prefixed frame deframer
package slfd_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam int         HEADER_LEN  = 4;
  localparam int         MAX_RES     = 4;
  localparam int         LEN_W       = 17;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 17'd256;

  // one result transaction
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } res_t;

  // results produced by one input byte, lowest item first
  typedef struct packed {
    logic [2:0]       cnt;
    res_t [MAX_RES-1:0] item;
  } res_bundle_t;

endpackage

@@ rtl/slfd_framer.sv @@
// Sync hunt, length check and body pass-through for one byte per step
module slfd_framer
  import slfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             step_en,
  input  logic [7:0]       rx_byte,
  output res_bundle_t      res_o
);

  logic [LEN_W-1:0] max_len_r;
  logic [7:0]       win_r [3];
  logic [7:0]       win_nxt [3];
  logic [1:0]       fill_r, fill_nxt;
  logic             in_body_r, in_body_nxt;
  logic [15:0]      bytes_left_r, bytes_left_nxt;

  logic [7:0]       w [4];
  logic [2:0]       n;
  logic             done;
  logic [LEN_W-1:0] total;
  logic             body_last;

  // per-byte decision
  always_comb begin
    res_o          = '0;
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    in_body_nxt    = in_body_r;
    bytes_left_nxt = bytes_left_r;
    body_last      = (bytes_left_r <= 16'd1);
    total          = '0;
    done           = 1'b0;
    n              = 3'd0;
    for (int i = 0; i < 4; i++) begin
      w[i] = 8'h00;
    end

    if (in_body_r) begin
      // body byte passes straight through
      res_o.cnt           = 3'd1;
      res_o.item[0].data  = rx_byte;
      res_o.item[0].first = 1'b0;
      res_o.item[0].last  = body_last;
      if (body_last) begin
        bytes_left_nxt = '0;
        in_body_nxt    = 1'b0;
      end else begin
        bytes_left_nxt = bytes_left_r - 16'd1;
      end
    end else begin
      // held bytes plus the new one, oldest first
      for (int i = 0; i < 3; i++) begin
        if (i < int'(fill_r)) w[i] = win_r[i];
      end
      w[fill_r] = rx_byte;
      n = {1'b0, fill_r} + 3'd1;

      // at most one rejection, so two passes settle the window
      for (int it = 0; it < 2; it++) begin
        if (!done) begin
          // drop leading bytes until the window opens with the sync pair
          for (int j = 0; j < 3; j++) begin
            if (n >= 3'd2 && !(w[0] == SYNC_BYTE && w[1] == SYNC_BYTE)) begin
              w[0] = w[1];
              w[1] = w[2];
              w[2] = w[3];
              w[3] = 8'h00;
              n    = n - 3'd1;
            end
          end
          // a lone byte is kept only if it can start a header
          if (n == 3'd1 && w[0] != SYNC_BYTE) n = 3'd0;
          if (n < 3'(HEADER_LEN)) begin
            done = 1'b1;
          end else begin
            total = LEN_W'({w[2], w[3]}) + LEN_W'(HEADER_LEN);
            if (total > max_len_r) begin
              // oversize length: drop the first header byte and hunt again
              w[0] = w[1];
              w[1] = w[2];
              w[2] = w[3];
              w[3] = 8'h00;
              n    = 3'd3;
            end else begin
              res_o.cnt = 3'(HEADER_LEN);
              for (int k = 0; k < HEADER_LEN; k++) begin
                res_o.item[k].data  = w[k];
                res_o.item[k].first = (k == 0);
                res_o.item[k].last  = (k == HEADER_LEN - 1) && (w[2] == 8'h00)
                                      && (w[3] == 8'h00);
              end
              if (w[2] != 8'h00 || w[3] != 8'h00) begin
                in_body_nxt    = 1'b1;
                bytes_left_nxt = {w[2], w[3]};
              end
              n    = 3'd0;
              done = 1'b1;
            end
          end
        end
      end

      // keep what is still held
      for (int i = 0; i < 3; i++) begin
        win_nxt[i] = (i < int'(n)) ? w[i] : 8'h00;
      end
      fill_nxt = n[1:0];
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= MAX_LEN_RESET;
      fill_r       <= '0;
      in_body_r    <= 1'b0;
      bytes_left_r <= '0;
      for (int i = 0; i < 3; i++) begin
        win_r[i] <= 8'h00;
      end
    end else begin
      if (cfg_wr_en) max_len_r <= cfg_wr_data;
      if (step_en) begin
        fill_r       <= fill_nxt;
        in_body_r    <= in_body_nxt;
        bytes_left_r <= bytes_left_nxt;
        win_r        <= win_nxt;
      end
    end
  end

endmodule

@@ rtl/slfd_out_fifo.sv @@
// Result queue taking up to four results a cycle and giving one
module slfd_out_fifo
  import slfd_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  res_bundle_t wr_res,
  output logic        room,
  output logic        out_tvalid,
  input  logic        out_tready,
  output res_t        out_res
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]    wr_cnt;
  logic          rd_en;

  // pointer and occupancy update
  always_comb begin
    wr_cnt     = wr_en ? wr_res.cnt : 3'd0;
    rd_en      = out_tvalid && out_tready;
    wr_ptr_nxt = wr_ptr_r + PW'(wr_cnt);
    rd_ptr_nxt = rd_ptr_r + PW'(rd_en);
    count_nxt  = count_r + CW'(wr_cnt) - CW'(rd_en);
  end

  assign room       = (count_r <= CW'(DEPTH - MAX_RES));
  assign out_tvalid = (count_r != '0);
  assign out_res    = mem[rd_ptr_r];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, written at consecutive slots
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (k < int'(wr_cnt)) mem[PW'(wr_ptr_r + PW'(k))] <= wr_res.item[k];
    end
  end

endmodule

@@ rtl/sync_length_frame_deframer_core.sv @@
// Top level of the length-prefixed frame deframer with 0xFF 0xFF sync
//
// Received bytes enter one per cycle through an input register; the hunt and
// length logic then decides each byte in a single pass and writes its
// results into a FIFO_DEPTH-entry result queue, which feeds the output
// stream one frame byte per transaction. A byte that completes a header
// yields four results at once, any other byte zero or one. Input is taken
// every cycle as long as the queue has four free slots, so with the output
// side always ready the block sustains one byte per cycle; the output port,
// one result per cycle, sets the long-run limit. A byte's first result
// is offered after the input register and the result queue.
module sync_length_frame_deframer_core
  import slfd_pkg::*;
#(
  parameter int FIFO_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,  // max_frame_len
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,     // [7:0] rx_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,    // [7:0] data_byte
  output logic [0:0]       out_tuser,    // [0] first_byte
  output logic             out_tlast     // last_byte
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        room;
  logic        step;
  res_bundle_t res;
  res_t        out_res;

  assign step      = s1_valid_r && room;
  assign in_tready = !s1_valid_r || room;

  // input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) s1_valid_nxt = 1'b1;
    else if (step)              s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) s1_byte_r <= in_tdata;
  end

  slfd_framer u_framer (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (step),
    .rx_byte     (s1_byte_r),
    .res_o       (res)
  );

  slfd_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (step),
    .wr_res     (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // output fields
  assign out_tdata    = out_res.data;
  assign out_tuser[0] = out_res.first;
  assign out_tlast    = out_res.last;

endmodule

@@ rtl/slfd_checker.sv @@
// Port-level checks for the deframer and their binding to the top level
module slfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser,
  input logic       out_tlast
);

  logic in_frame_r;

  // tracks whether a frame has started but not yet ended on the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      if (out_tlast)         in_frame_r <= 1'b0;
      else if (out_tuser[0]) in_frame_r <= 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // a frame opens only when none is open, and its first byte never ends it
  a_first_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[0] |-> !in_frame_r && !out_tlast)
    else $error("frame start inside a frame");

  // every other byte belongs to an open frame
  a_body_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tuser[0] |-> in_frame_r)
    else $error("frame byte outside a frame");

  // queue is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind sync_length_frame_deframer_core slfd_checker u_slfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ bench/sync_length_frame_deframer_core_tb.sv @@
// Self-checking bench for the sync/length frame deframer: bursty bytes in, frame bytes checked
`timescale 1ns / 100ps

module sync_length_frame_deframer_core_tb
  import slfd_pkg::*;
();

  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata    = '0;   // [7:0] rx_byte
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [7:0]       out_tdata;          // [7:0] data_byte
  logic [0:0]       out_tuser;          // [0] first_byte
  logic             out_tlast;          // last_byte

  sync_length_frame_deframer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // bytes waiting to be sent and frame bytes waiting to come out
  logic [7:0] rx_pending_q[$];
  res_t       frame_bytes_q[$];
  int         rx_queued = 0;
  int         err_cnt   = 0;

  // predictor copy of the deframer state
  logic [LEN_W-1:0] max_frame_len_q = MAX_LEN_RESET;
  logic [7:0]       hunt_win[3]     = '{default: 8'h00};
  int               hunt_fill       = 0;
  logic             in_frame        = 1'b0;
  logic [LEN_W-1:0] body_left       = '0;

  // idling controls, set between phases, and the counters that apply them
  int          gap_max     = 0;
  logic [15:0] stall_pat   = 16'hFFFF;
  int          hold_reqs   = 0;
  int          hold_served = 0;
  int          hold_left   = 0;
  logic [3:0]  pat_idx     = '0;
  int          burst_left  = 0;
  int          gap_left    = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // works out the frame bytes one received byte releases
  task automatic decode_rx_byte(input logic [7:0] rx);
    logic [7:0]  win_b[4];
    int          n;
    logic [17:0] total;
    res_t        r;
    bit          done;
    if (in_frame) begin
      r.data  = rx;
      r.first = 1'b0;
      r.last  = (body_left <= 1);
      frame_bytes_q.push_back(r);
      if (r.last) begin
        body_left = '0;
        in_frame  = 1'b0;
      end else begin
        body_left = body_left - 1'b1;
      end
      return;
    end
    for (int i = 0; i < hunt_fill; i++) win_b[i] = hunt_win[i];
    win_b[hunt_fill] = rx;
    n    = hunt_fill + 1;
    done = 1'b0;
    while (!done) begin
      // drop bytes until the window opens with the sync pair
      while (n >= 2 && !(win_b[0] == SYNC_BYTE && win_b[1] == SYNC_BYTE)) begin
        for (int i = 1; i < n; i++) win_b[i-1] = win_b[i];
        n--;
      end
      if (n == 1 && win_b[0] != SYNC_BYTE) n = 0;
      if (n < HEADER_LEN) begin
        done = 1'b1;
      end else begin
        total = 18'({win_b[2], win_b[3]}) + 18'(HEADER_LEN);
        if (total > 18'(max_frame_len_q)) begin
          // too long: slide past the first sync byte and hunt again
          for (int i = 1; i < n; i++) win_b[i-1] = win_b[i];
          n--;
        end else begin
          for (int i = 0; i < HEADER_LEN; i++) begin
            r.data  = win_b[i];
            r.first = (i == 0);
            r.last  = (i == HEADER_LEN - 1) && (total == 18'(HEADER_LEN));
            frame_bytes_q.push_back(r);
          end
          if (total > 18'(HEADER_LEN)) begin
            in_frame  = 1'b1;
            body_left = LEN_W'(total - 18'(HEADER_LEN));
          end
          n    = 0;
          done = 1'b1;
        end
      end
    end
    for (int i = 0; i < 3; i++) hunt_win[i] = (i < n) ? win_b[i] : 8'h00;
    hunt_fill = n;
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (rx_pending_q.size() != 0) begin
        in_tdata  <= rx_pending_q.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: rotating ready pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      pat_idx     <= '0;
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_served != hold_reqs) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= stall_pat[pat_idx];
      pat_idx    <= pat_idx + 1'b1;
    end
  end

  // prediction on input transactions, checking on output transactions
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) decode_rx_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (frame_bytes_q.size() == 0) begin
          $error("unexpected output transaction: data_byte %h first_byte %b last_byte %b",
                 out_tdata, out_tuser[0], out_tlast);
          err_cnt++;
        end else begin
          want = frame_bytes_q.pop_front();
          if (out_tdata !== want.data) begin
            $error("data_byte mismatch: expected %h, actual %h", want.data, out_tdata);
            err_cnt++;
          end
          if (out_tuser[0] !== want.first) begin
            $error("first_byte mismatch: expected %b, actual %b", want.first, out_tuser[0]);
            err_cnt++;
          end
          if (out_tlast !== want.last) begin
            $error("last_byte mismatch: expected %b, actual %b", want.last, out_tlast);
            err_cnt++;
          end
        end
      end
    end
  end

  task automatic put_rx(input logic [7:0] b);
    rx_pending_q.push_back(b);
    rx_queued++;
  endtask

  // sync pair, big-endian length, then the body if asked
  task automatic queue_frame(input int len, input bit with_body);
    put_rx(SYNC_BYTE);
    put_rx(SYNC_BYTE);
    put_rx(len[15:8]);
    put_rx(len[7:0]);
    if (with_body) repeat (len) put_rx(8'($urandom));
  endtask

  // mostly good frames, the rest oversize headers, noise and broken syncs
  task automatic queue_traffic(input int n_items);
    int  start;
    int  lim;
    int  pick;
    int  len;
    bit  big;
    start = rx_queued;
    lim   = int'(max_frame_len_q) - HEADER_LEN;
    // with a huge limit stray sync pairs, or an oversize header whose high
    // length byte re-syncs, could open endless bodies
    big   = (lim > 1000);
    while (rx_queued - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if (lim >= 0 && lim <= 40 && $urandom_range(0, 3) == 0) len = lim;
        else len = $urandom_range(0, (lim > 12 || lim < 0) ? 12 : lim);
        queue_frame(len, 1'b1);
      end else if (pick < 75 && !big) begin
        len = (lim < 0) ? $urandom_range(0, 255) : lim + 1 + $urandom_range(0, 20);
        if (len > 65535) len = 65535;
        queue_frame(len, 1'b0);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) begin
          if (!big && $urandom_range(0, 2) == 0) put_rx(SYNC_BYTE);
          else put_rx(8'($urandom_range(0, 254)));
        end
      end else begin
        // lone sync byte followed by junk
        put_rx(SYNC_BYTE);
        put_rx(8'($urandom_range(0, 254)));
      end
    end
  endtask

  // all bytes accepted, all frame bytes out, then a little extra time
  task automatic wait_idle();
    @(negedge clk);
    while (rx_pending_q.size() != 0 || in_tvalid || frame_bytes_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic start_phase(input logic [LEN_W-1:0] len_limit, input int gap,
                             input logic [15:0] pat);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len_limit;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
    max_frame_len_q = len_limit;
    gap_max         = gap;
    stall_pat       = pat;
  endtask

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, at the reset limit
    gap_max   = 2;
    stall_pat = 16'hB6DB;
    put_rx(8'h00);                                  // lone non-sync byte
    put_rx(SYNC_BYTE); put_rx(8'h7F);               // lone sync byte then junk
    queue_frame(0, 1'b0);                           // header-only frame
    queue_frame(2, 1'b1);
    queue_frame(256, 1'b0);                         // just over the limit
    put_rx(SYNC_BYTE); put_rx(SYNC_BYTE); put_rx(SYNC_BYTE);
    put_rx(8'h00); put_rx(8'h00);                   // rejected, then re-synced one byte on

    // limit below the header size: nothing gets through
    start_phase(LEN_W'(3), 5, 16'($urandom) | 16'h0001);
    queue_traffic(10);

    // header-only frames are the only ones that fit
    start_phase(LEN_W'(4), 0, 16'h5555);
    queue_traffic(20);

    start_phase(LEN_W'($urandom_range(8, 40)), 4, 16'($urandom) | 16'h0001);
    queue_traffic(30);

    start_phase(LEN_W'(65539), 1, 16'hFFFF);
    queue_traffic(10);

    // one frame with a non-zero length high byte
    start_phase(LEN_W'(16'hFFFC), 0, 16'h00FF);
    queue_frame(256, 1'b1);
    queue_traffic(10);

    // long receiver hold-off while the sender keeps pushing
    start_phase(LEN_W'($urandom_range(5, 300)), 0, 16'hFFFF);
    hold_reqs++;
    queue_traffic(40);

    start_phase(LEN_W'(256), 8, 16'($urandom) | 16'h0001);
    queue_traffic(20);

    wait_idle();
    if (err_cnt == 0 && frame_bytes_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
